### design/owm_pkg.sv
// owm_pkg: shared types, codes and reset values for the one-wire bus master.
// Used by owm_regs, owm_seq and onewire_bus_master; depends on nothing.
package owm_pkg;

   // Default number of bus channels
   localparam int CHANNELS_DEF = 2;

   // Command codes carried in the op field
   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_RESET = 3'd1;
   localparam logic [2:0] OP_WBYTE = 3'd2;
   localparam logic [2:0] OP_RBYTE = 3'd3;
   localparam logic [2:0] OP_WBIT  = 3'd4;
   localparam logic [2:0] OP_RBIT  = 3'd5;

   // Configuration register indexes
   localparam logic [2:0] CSR_RESET_LOW     = 3'd0;
   localparam logic [2:0] CSR_PRESENCE_WAIT = 3'd1;
   localparam logic [2:0] CSR_RESET_TAIL    = 3'd2;
   localparam logic [2:0] CSR_SHORT_LOW     = 3'd3;
   localparam logic [2:0] CSR_READ_SAMPLE   = 3'd4;
   localparam logic [2:0] CSR_READ_REST     = 3'd5;
   localparam logic [2:0] CSR_WRITE_SLOT    = 3'd6;
   localparam logic [2:0] CSR_RECOVERY      = 3'd7;

   // Configuration register reset values
   localparam logic [9:0] RST_RESET_LOW     = 10'd600;
   localparam logic [9:0] RST_PRESENCE_WAIT = 10'd100;
   localparam logic [9:0] RST_RESET_TAIL    = 10'd380;
   localparam logic [3:0] RST_SHORT_LOW     = 4'd1;
   localparam logic [5:0] RST_READ_SAMPLE   = 6'd12;
   localparam logic [6:0] RST_READ_REST     = 7'd46;
   localparam logic [6:0] RST_WRITE_SLOT    = 7'd60;
   localparam logic [5:0] RST_RECOVERY      = 6'd2;

   // Timing configuration as seen by the sequencer
   typedef struct packed {
      logic [9:0] reset_low;
      logic [9:0] presence_wait;
      logic [9:0] reset_tail;
      logic [3:0] short_low;
      logic [5:0] read_sample;
      logic [6:0] read_rest;
      logic [6:0] write_slot;
      logic [5:0] recovery;
   } cfg_type;

   // One input item
   typedef struct packed {
      logic [2:0] op;
      logic       channel;
      logic [7:0] data_value;
      logic       line_level;
   } req_type;

   // One result item
   typedef struct packed {
      logic       drive_low;
      logic       active_channel;
      logic       done_res;
      logic       presence;
      logic [7:0] read_data;
      logic       rejected;
   } rsp_type;

   // A zero length in a one-based timing field counts as one
   function automatic logic [9:0] at_least_one(input logic [9:0] v);
      return (v == 10'd0) ? 10'd1 : v;
   endfunction

endpackage

### design/owm_regs.sv
// owm_regs: timing configuration registers of the one-wire bus master.
// Depends on owm_pkg (cfg_type, register indexes, reset values).
module owm_regs (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [2:0]       csr_index,
   input  logic [9:0]       csr_wr_data,
   output owm_pkg::cfg_type cfg
);
   import owm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Register write decode, data truncated to each field's width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RESET_LOW:     cfg_in.reset_low     = csr_wr_data;
            CSR_PRESENCE_WAIT: cfg_in.presence_wait = csr_wr_data;
            CSR_RESET_TAIL:    cfg_in.reset_tail    = csr_wr_data;
            CSR_SHORT_LOW:     cfg_in.short_low     = csr_wr_data[3:0];
            CSR_READ_SAMPLE:   cfg_in.read_sample   = csr_wr_data[5:0];
            CSR_READ_REST:     cfg_in.read_rest     = csr_wr_data[6:0];
            CSR_WRITE_SLOT:    cfg_in.write_slot    = csr_wr_data[6:0];
            CSR_RECOVERY:      cfg_in.recovery      = csr_wr_data[5:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low     <= RST_RESET_LOW;
         cfg_ff.presence_wait <= RST_PRESENCE_WAIT;
         cfg_ff.reset_tail    <= RST_RESET_TAIL;
         cfg_ff.short_low     <= RST_SHORT_LOW;
         cfg_ff.read_sample   <= RST_READ_SAMPLE;
         cfg_ff.read_rest     <= RST_READ_REST;
         cfg_ff.write_slot    <= RST_WRITE_SLOT;
         cfg_ff.recovery      <= RST_RECOVERY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### design/owm_seq.sv
// owm_seq: slot sequencer of the one-wire bus master; advances one item per step.
// Depends on owm_pkg (req_type, rsp_type, cfg_type, op codes, at_least_one).
module owm_seq #(
   parameter int CHANNELS = owm_pkg::CHANNELS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  owm_pkg::req_type req,
   input  owm_pkg::cfg_type cfg,
   output owm_pkg::rsp_type rsp
);
   import owm_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_RST_LOW  = 3'd1,
      PH_RST_WAIT = 3'd2,
      PH_RST_TAIL = 3'd3,
      PH_LOW      = 3'd4,
      PH_SAMPLE   = 3'd5,
      PH_REST     = 3'd6,
      PH_RECOVER  = 3'd7
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [9:0] tick_count_ff, tick_count_in;
   logic [2:0] bit_index_ff, bit_index_in;
   logic [7:0] shift_data_ff, shift_data_in;
   logic [2:0] command_kind_ff, command_kind_in;
   logic       channel_sel_ff, channel_sel_in;
   logic       presence_ff, presence_in;
   logic [7:0] read_latch_ff, read_latch_in;

   logic       is_read, is_byte, cur_bit;
   logic [9:0] slot_len, short_len, low_len, rest_len, phase_len;
   logic       slot_end, done, rej;

   // Command class and current bit
   assign is_read = (command_kind_ff == OP_RBYTE) || (command_kind_ff == OP_RBIT);
   assign is_byte = (command_kind_ff == OP_WBYTE) || (command_kind_ff == OP_RBYTE);
   assign cur_bit = shift_data_ff[bit_index_ff];

   // Length of the current phase in ticks
   assign slot_len  = at_least_one({3'd0, cfg.write_slot});
   assign short_len = at_least_one({6'd0, cfg.short_low});
   assign low_len   = (!is_read && !cur_bit) ? slot_len : short_len;

   always_comb begin
      if (is_read)
         rest_len = {3'd0, cfg.read_rest};
      else if (!cur_bit)
         rest_len = 10'd0;
      else if (slot_len > short_len)
         rest_len = slot_len - short_len;
      else
         rest_len = 10'd0;
   end

   always_comb begin
      unique case (phase_ff)
         PH_RST_LOW:  phase_len = at_least_one(cfg.reset_low);
         PH_RST_WAIT: phase_len = at_least_one(cfg.presence_wait);
         PH_RST_TAIL: phase_len = at_least_one(cfg.reset_tail);
         PH_LOW:      phase_len = low_len;
         PH_SAMPLE:   phase_len = at_least_one({4'd0, cfg.read_sample});
         PH_REST:     phase_len = rest_len;
         PH_RECOVER:  phase_len = {4'd0, cfg.recovery};
         default:     phase_len = 10'd1;
      endcase
   end

   // Next state for one item
   always_comb begin
      phase_in        = phase_ff;
      tick_count_in   = tick_count_ff;
      bit_index_in    = bit_index_ff;
      shift_data_in   = shift_data_ff;
      command_kind_in = command_kind_ff;
      channel_sel_in  = channel_sel_ff;
      presence_in     = presence_ff;
      read_latch_in   = read_latch_ff;
      slot_end        = 1'b0;
      done            = 1'b0;
      rej             = 1'b0;

      if (step) begin
         case (req.op) inside
            OP_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  if ({1'b0, tick_count_ff} + 11'd1 < {1'b0, phase_len}) begin
                     tick_count_in = tick_count_ff + 10'd1;
                  end else begin
                     tick_count_in = 10'd0;
                     unique case (phase_ff)
                        PH_RST_LOW: phase_in = PH_RST_WAIT;
                        PH_RST_WAIT: begin
                           presence_in = !req.line_level;
                           phase_in    = PH_RST_TAIL;
                        end
                        PH_RST_TAIL: begin
                           phase_in = PH_IDLE;
                           done     = 1'b1;
                        end
                        PH_LOW: begin
                           if (is_read)
                              phase_in = PH_SAMPLE;
                           else if (rest_len == 10'd0)
                              slot_end = 1'b1;
                           else
                              phase_in = PH_REST;
                        end
                        PH_SAMPLE: begin
                           shift_data_in[bit_index_ff] = shift_data_ff[bit_index_ff]
                                                         | req.line_level;
                           if (rest_len == 10'd0)
                              slot_end = 1'b1;
                           else
                              phase_in = PH_REST;
                        end
                        PH_REST:    slot_end = 1'b1;
                        PH_RECOVER: phase_in = PH_LOW;
                        default:    phase_in = PH_IDLE;
                     endcase
                  end
               end
            end
            OP_RESET, OP_WBYTE, OP_RBYTE, OP_WBIT, OP_RBIT: begin
               if (phase_ff != PH_IDLE || 32'(req.channel) >= 32'(CHANNELS)) begin
                  rej = 1'b1;
               end else begin
                  command_kind_in = req.op;
                  channel_sel_in  = req.channel;
                  bit_index_in    = 3'd0;
                  tick_count_in   = 10'd0;
                  if (req.op == OP_RESET) begin
                     shift_data_in = 8'd0;
                     phase_in      = PH_RST_LOW;
                  end else begin
                     if (req.op == OP_WBYTE)
                        shift_data_in = req.data_value;
                     else if (req.op == OP_WBIT)
                        shift_data_in = {7'd0, req.data_value[0]};
                     else
                        shift_data_in = 8'd0;
                     phase_in = PH_LOW;
                  end
               end
            end
            default: ;
         endcase

         // End of a bit slot: next bit of a byte, or finish the command
         if (slot_end) begin
            if (is_byte && bit_index_ff != 3'd7) begin
               bit_index_in = bit_index_ff + 3'd1;
               phase_in     = (cfg.recovery == 6'd0) ? PH_LOW : PH_RECOVER;
            end else begin
               if (is_read)
                  read_latch_in = shift_data_in;
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
         end
      end
   end

   // Result reflects the state after this item
   always_comb begin
      rsp.drive_low      = (phase_in == PH_RST_LOW) || (phase_in == PH_LOW);
      rsp.active_channel = channel_sel_in;
      rsp.done_res       = done;
      rsp.presence       = presence_in;
      rsp.read_data      = read_latch_in;
      rsp.rejected       = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         tick_count_ff   <= 10'd0;
         bit_index_ff    <= 3'd0;
         shift_data_ff   <= 8'd0;
         command_kind_ff <= 3'd0;
         channel_sel_ff  <= 1'b0;
         presence_ff     <= 1'b0;
         read_latch_ff   <= 8'd0;
      end else begin
         phase_ff        <= phase_in;
         tick_count_ff   <= tick_count_in;
         bit_index_ff    <= bit_index_in;
         shift_data_ff   <= shift_data_in;
         command_kind_ff <= command_kind_in;
         channel_sel_ff  <= channel_sel_in;
         presence_ff     <= presence_in;
         read_latch_ff   <= read_latch_in;
      end
   end

endmodule

### design/onewire_bus_master.sv
// One-wire bus master, top level. Depends on owm_pkg, owm_regs and owm_seq.
//
// Usage: every item on the req_ channel is either a tick (one microsecond of
// bus time, carrying the sampled line level) or a command (reset with
// presence detect, byte write, byte read, bit write, bit read) for one
// channel. Each item gives exactly one item on the rsp_ channel with the
// line drive, active channel, done, presence, last read byte and a reject
// flag for a command that arrives while another runs or on a channel >= CHANNELS.
// An item is taken when req_valid is high and req_stall low; a result is
// taken when rsp_valid is high and rsp_stall low.
// An accepted item waits in the input register and its result in the result
// register. Throughput: one item per cycle while the result side does not
// stall; the sequencer's state update for an item is combinational logic
// between the two registers.
// Reset (synchronous) empties both registers, returns the sequencer to idle
// and loads the timing registers with their default values.
// While rsp_stall is high the result register holds; one more item may
// wait in the input register, after which req_stall rises.
// The csr_ port writes timing registers; the user must use it only while idle, as the block does not enforce this.
module onewire_bus_master #(
   parameter int CHANNELS = owm_pkg::CHANNELS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_op,
   input  logic       req_channel,
   input  logic [7:0] req_data_value,
   input  logic       req_line_level,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_drive_low,
   output logic       rsp_active_channel,
   output logic       rsp_done_res,
   output logic       rsp_presence,
   output logic [7:0] rsp_read_data,
   output logic       rsp_rejected,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_index,
   input  logic [9:0] csr_wr_data
);
   import owm_pkg::*;

   cfg_type cfg;
   req_type req_ff, req_in;
   logic    in_valid_ff, in_valid_in;
   rsp_type rsp_ff, seq_rsp;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    out_ready, in_take, step;

   // Handshake: result register frees up, input register moves forward
   assign out_ready   = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = in_valid_ff && !out_ready;
   assign in_take     = req_valid && !req_stall;
   assign step        = in_valid_ff && out_ready;
   assign in_valid_in = in_take || (in_valid_ff && !step);
   assign rsp_valid_in = step || (rsp_valid_ff && rsp_stall);

   always_comb begin
      req_in            = req_ff;
      if (in_take) begin
         req_in.op         = req_op;
         req_in.channel    = req_channel;
         req_in.data_value = req_data_value;
         req_in.line_level = req_line_level;
      end
   end

   owm_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   owm_seq #(
      .CHANNELS (CHANNELS)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req_ff),
      .cfg   (cfg),
      .rsp   (seq_rsp)
   );

   // Input and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (step)
         rsp_ff <= seq_rsp;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_drive_low      = rsp_ff.drive_low;
   assign rsp_active_channel = rsp_ff.active_channel;
   assign rsp_done_res       = rsp_ff.done_res;
   assign rsp_presence       = rsp_ff.presence;
   assign rsp_read_data      = rsp_ff.read_data;
   assign rsp_rejected       = rsp_ff.rejected;

   // A finished command leaves the line released
   a_done_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res |-> !rsp_ff.drive_low)
      else $error("done result still drives the line low");

   // A finishing item is never a rejected command
   a_done_not_rej: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res |-> !rsp_ff.rejected)
      else $error("result both done and rejected");

   // Input backpressure only when an item is held and the result side is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled without a blocked result");

   // Each step produces a valid result in the next cycle
   a_step_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("stepped item produced no result");

endmodule

### test/owm_checker.sv
`timescale 1ns / 100ps
// owm_checker: predicts every result of the one-wire bus master and compares it.
// Watches the req_, rsp_ and csr_ ports of onewire_bus_master; depends on owm_pkg.
module owm_checker #(
   parameter int CHANNELS = owm_pkg::CHANNELS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [2:0] req_op,
   input  logic       req_channel,
   input  logic [7:0] req_data_value,
   input  logic       req_line_level,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_drive_low,
   input  logic       rsp_active_channel,
   input  logic       rsp_done_res,
   input  logic       rsp_presence,
   input  logic [7:0] rsp_read_data,
   input  logic       rsp_rejected,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_index,
   input  logic [9:0] csr_wr_data,
   output int         fail_count,
   output int         pending,
   output logic       bus_busy,
   output int         checked,
   output int         done_seen,
   output int         reject_seen
);
   import owm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_RST_LOW, ST_RST_WAIT, ST_RST_TAIL,
      ST_LOW, ST_SAMPLE, ST_REST, ST_RECOVER
   } bus_phase_type;

   // Shadow of the sequencer and of the timing registers
   cfg_type       tcfg;
   bus_phase_type ph;
   logic [9:0]    ticks;
   logic [2:0]    bit_pos;
   logic [7:0]    shreg;
   logic [2:0]    cmd;
   logic          chan;
   logic          pres;
   logic [7:0]    rd_byte;

   // Results owed by the block, oldest first
   rsp_type due_rsp[$];

   function automatic int floor1(input int v);
      return (v == 0) ? 1 : v;
   endfunction

   function automatic bit reading();
      return cmd == OP_RBYTE || cmd == OP_RBIT;
   endfunction

   function automatic bit byte_cmd();
      return cmd == OP_WBYTE || cmd == OP_RBYTE;
   endfunction

   // Low part of a slot: whole slot for a written zero, else the short pulse
   function automatic int low_ticks();
      if (!reading() && !shreg[bit_pos])
         return floor1(int'(tcfg.write_slot));
      return floor1(int'(tcfg.short_low));
   endfunction

   // Released part of a slot after the low pulse or the read sample
   function automatic int rest_ticks();
      int s, l;
      if (reading())
         return int'(tcfg.read_rest);
      if (!shreg[bit_pos])
         return 0;
      s = floor1(int'(tcfg.write_slot));
      l = floor1(int'(tcfg.short_low));
      return (s > l) ? s - l : 0;
   endfunction

   function automatic int cur_len();
      case (ph)
         ST_RST_LOW:  return floor1(int'(tcfg.reset_low));
         ST_RST_WAIT: return floor1(int'(tcfg.presence_wait));
         ST_RST_TAIL: return floor1(int'(tcfg.reset_tail));
         ST_LOW:      return low_ticks();
         ST_SAMPLE:   return floor1(int'(tcfg.read_sample));
         ST_REST:     return rest_ticks();
         ST_RECOVER:  return int'(tcfg.recovery);
         default:     return 1;
      endcase
   endfunction

   function automatic void enter(input bus_phase_type p);
      ph = p;
      ticks = 10'd0;
   endfunction

   // Close a bit slot: next bit of a byte, or the command is complete
   function automatic bit finish_slot();
      if (byte_cmd() && bit_pos < 3'd7) begin
         bit_pos = bit_pos + 3'd1;
         if (tcfg.recovery == 6'd0)
            enter(ST_LOW);
         else
            enter(ST_RECOVER);
         return 1'b0;
      end
      if (reading())
         rd_byte = shreg;
      enter(ST_IDLE);
      return 1'b1;
   endfunction

   function automatic bit after_low();
      if (rest_ticks() == 0)
         return finish_slot();
      enter(ST_REST);
      return 1'b0;
   endfunction

   // One microsecond of bus time; returns 1 when the running command ends
   function automatic bit tick_bus(input logic level);
      if (ph == ST_IDLE)
         return 1'b0;
      if (int'(ticks) + 1 < cur_len()) begin
         ticks = ticks + 10'd1;
         return 1'b0;
      end
      case (ph)
         ST_RST_LOW: enter(ST_RST_WAIT);
         ST_RST_WAIT: begin
            pres = !level;
            enter(ST_RST_TAIL);
         end
         ST_RST_TAIL: begin
            enter(ST_IDLE);
            return 1'b1;
         end
         ST_LOW: begin
            if (reading())
               enter(ST_SAMPLE);
            else
               return after_low();
         end
         ST_SAMPLE: begin
            shreg[bit_pos] = shreg[bit_pos] | level;
            return after_low();
         end
         ST_REST: return finish_slot();
         default: enter(ST_LOW);
      endcase
      return 1'b0;
   endfunction

   // Expected result of one accepted item, advancing the shadow state
   function automatic rsp_type bus_response(input logic [2:0] op, input logic ch,
                                            input logic [7:0] data, input logic level);
      rsp_type r;
      bit      done, rej;
      done = 1'b0;
      rej  = 1'b0;
      if (op == OP_TICK) begin
         done = tick_bus(level);
      end else if (op <= OP_RBIT) begin
         if (ph != ST_IDLE || int'(ch) >= CHANNELS) begin
            rej = 1'b1;
         end else begin
            cmd     = op;
            chan    = ch;
            bit_pos = 3'd0;
            case (op)
               OP_WBYTE: shreg = data;
               OP_WBIT:  shreg = {7'd0, data[0]};
               default:  shreg = 8'd0;
            endcase
            if (op == OP_RESET)
               enter(ST_RST_LOW);
            else
               enter(ST_LOW);
         end
      end
      r.drive_low      = (ph == ST_RST_LOW || ph == ST_LOW);
      r.active_channel = chan;
      r.done_res       = done;
      r.presence       = pres;
      r.read_data      = rd_byte;
      r.rejected       = rej;
      return r;
   endfunction

   function automatic void reset_model();
      tcfg = '{reset_low: RST_RESET_LOW, presence_wait: RST_PRESENCE_WAIT,
               reset_tail: RST_RESET_TAIL, short_low: RST_SHORT_LOW,
               read_sample: RST_READ_SAMPLE, read_rest: RST_READ_REST,
               write_slot: RST_WRITE_SLOT, recovery: RST_RECOVERY};
      ph      = ST_IDLE;
      ticks   = 10'd0;
      bit_pos = 3'd0;
      shreg   = 8'd0;
      cmd     = OP_TICK;
      chan    = 1'b0;
      pres    = 1'b0;
      rd_byte = 8'd0;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      if (fail_count < 40)
         $display("%0t ns: %s wrong on result %0d: got %h, expected %h",
                  $realtime, what, checked, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch
      rsp_type got, want;
      if (reset) begin
         reset_model();
         due_rsp.delete();
         fail_count  = 0;
         checked     = 0;
         done_seen   = 0;
         reject_seen = 0;
      end else begin
         // timing register writes land before any item of this edge
         if (csr_wr_en) begin
            case (csr_index)
               CSR_RESET_LOW:     tcfg.reset_low     = csr_wr_data;
               CSR_PRESENCE_WAIT: tcfg.presence_wait = csr_wr_data;
               CSR_RESET_TAIL:    tcfg.reset_tail    = csr_wr_data;
               CSR_SHORT_LOW:     tcfg.short_low     = csr_wr_data[3:0];
               CSR_READ_SAMPLE:   tcfg.read_sample   = csr_wr_data[5:0];
               CSR_READ_REST:     tcfg.read_rest     = csr_wr_data[6:0];
               CSR_WRITE_SLOT:    tcfg.write_slot    = csr_wr_data[6:0];
               default:           tcfg.recovery      = csr_wr_data[5:0];
            endcase
         end
         // result side
         if (rsp_valid && !rsp_stall) begin
            got.drive_low      = rsp_drive_low;
            got.active_channel = rsp_active_channel;
            got.done_res       = rsp_done_res;
            got.presence       = rsp_presence;
            got.read_data      = rsp_read_data;
            got.rejected       = rsp_rejected;
            if (due_rsp.size() == 0) begin
               report_mismatch("unexpected item", rsp_read_data, 8'h00);
            end else begin
               want = due_rsp.pop_front();
               if (got.drive_low !== want.drive_low)
                  report_mismatch("drive_low", 8'(got.drive_low), 8'(want.drive_low));
               if (got.active_channel !== want.active_channel)
                  report_mismatch("active_channel", 8'(got.active_channel),
                                  8'(want.active_channel));
               if (got.done_res !== want.done_res)
                  report_mismatch("done_res", 8'(got.done_res), 8'(want.done_res));
               if (got.presence !== want.presence)
                  report_mismatch("presence", 8'(got.presence), 8'(want.presence));
               if (got.read_data !== want.read_data)
                  report_mismatch("read_data", got.read_data, want.read_data);
               if (got.rejected !== want.rejected)
                  report_mismatch("rejected", 8'(got.rejected), 8'(want.rejected));
            end
            checked++;
         end
         // request side
         if (req_valid && !req_stall) begin
            want = bus_response(req_op, req_channel, req_data_value, req_line_level);
            if (want.done_res)
               done_seen++;
            if (want.rejected)
               reject_seen++;
            due_rsp.push_back(want);
         end
      end
      pending  <= due_rsp.size();
      bus_busy <= (ph != ST_IDLE);
   end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for onewire_bus_master; owm_checker does the checking.
// Depends on owm_pkg, onewire_bus_master and owm_checker.
module tb_top;
   import owm_pkg::*;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [2:0] req_op         = OP_TICK;
   logic       req_channel    = 1'b0;
   logic [7:0] req_data_value = 8'd0;
   logic       req_line_level = 1'b1;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic       rsp_drive_low;
   logic       rsp_active_channel;
   logic       rsp_done_res;
   logic       rsp_presence;
   logic [7:0] rsp_read_data;
   logic       rsp_rejected;
   logic       csr_wr_en      = 1'b0;
   logic [2:0] csr_index      = CSR_RESET_LOW;
   logic [9:0] csr_wr_data    = 10'd0;

   int   fail_count, pending, checked, done_seen, reject_seen;
   logic bus_busy;

   bit         send_idle = 1'b0;
   bit         recv_idle = 1'b0;
   int         stall_left = 0;
   int         sent_items = 0;
   int         setups = 0;
   logic [9:0] timing [8];

   onewire_bus_master u_top (.*);

   owm_checker u_checker (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // result side back-pressure in bursts of random length
   always @(negedge clock) begin
      if (reset || !recv_idle) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 13);
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // One item, preceded now and then by a burst with valid low
   task automatic send_item(input logic [2:0] op, input logic ch, input logic [7:0] data,
                            input logic level);
      int gap;
      gap = 0;
      if (send_idle && $urandom_range(0, 11) == 0)
         gap = $urandom_range(1, 14);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_op         <= op;
      req_channel    <= ch;
      req_data_value <= data;
      req_line_level <= level;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_items++;
   endtask

   // Ticks until the sequencer is idle; noise is the percentage of stray commands
   task automatic drain_bus(input int noise, input int lvl);
      logic level;
      do begin
         level = (lvl < 0) ? 1'($urandom_range(0, 1)) : 1'(lvl);
         if (noise > 0 && $urandom_range(0, 99) < noise)
            send_item(3'($urandom_range(1, 7)), 1'($urandom_range(0, 1)), 8'($urandom),
                      level);
         else
            send_item(OP_TICK, 1'($urandom_range(0, 1)), 8'($urandom), level);
      end while (bus_busy);
   endtask

   task automatic run_command(input logic [2:0] op, input logic ch, input logic [7:0] data,
                              input int lvl, input int noise);
      send_item(op, ch, data, 1'($urandom_range(0, 1)));
      drain_bus(noise, lvl);
   endtask

   // Bring the bus to rest and let every owed result come back
   task automatic settle();
      drain_bus(0, -1);
      @(negedge clock);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic apply_timing(input logic [9:0] low_t, wait_t, tail_t, short_t,
                               input logic [9:0] sample_t, rest_t, slot_t, recov_t);
      timing[CSR_RESET_LOW]     = low_t;
      timing[CSR_PRESENCE_WAIT] = wait_t;
      timing[CSR_RESET_TAIL]    = tail_t;
      timing[CSR_SHORT_LOW]     = short_t;
      timing[CSR_READ_SAMPLE]   = sample_t;
      timing[CSR_READ_REST]     = rest_t;
      timing[CSR_WRITE_SLOT]    = slot_t;
      timing[CSR_RECOVERY]      = recov_t;
      for (int i = 0; i < 8; i++) begin
         @(negedge clock);
         csr_wr_en   <= 1'b1;
         csr_index   <= 3'(i);
         csr_wr_data <= timing[i];
      end
      @(negedge clock);
      csr_wr_en <= 1'b0;
      setups++;
   endtask

   // Mostly complete commands with random content, some stray items
   task automatic random_phase(input int quota, input bit calm);
      int start, pick;
      logic ch;
      logic [7:0] data;
      start = sent_items;
      while (sent_items - start < quota) begin
         send_idle = !calm && $urandom_range(0, 3) != 0;
         recv_idle = !calm && $urandom_range(0, 3) != 0;
         pick = $urandom_range(0, 99);
         ch   = 1'($urandom_range(0, 1));
         data = 8'($urandom);
         if (pick < 15)
            run_command(OP_RESET, ch, data, -1, 4);
         else if (pick < 40)
            run_command(OP_WBYTE, ch, data, -1, 4);
         else if (pick < 65)
            run_command(OP_RBYTE, ch, data, -1, 4);
         else if (pick < 78)
            run_command(OP_WBIT, ch, data, -1, 4);
         else if (pick < 92)
            run_command(OP_RBIT, ch, data, -1, 4);
         else if (pick < 96)
            send_item(3'($urandom_range(6, 7)), ch, data, 1'($urandom_range(0, 1)));
         else
            send_item(OP_TICK, ch, data, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // power-on timing: one bit written, one bit read
      run_command(OP_WBIT, 1'b1, 8'hA5, -1, 0);
      run_command(OP_RBIT, 1'b0, 8'h00, -1, 0);
      settle();

      // all zero: one-based lengths act as one, rest and recovery skipped
      apply_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
      run_command(OP_RESET, 1'b0, 8'h00, 0, 0);
      run_command(OP_RESET, 1'b1, 8'hFF, 1, 0);
      run_command(OP_WBYTE, 1'b0, 8'h00, -1, 0);
      run_command(OP_WBYTE, 1'b1, 8'hFF, -1, 0);
      run_command(OP_WBIT, 1'b0, 8'hFE, -1, 0);
      run_command(OP_WBIT, 1'b1, 8'h01, -1, 0);
      run_command(OP_RBYTE, 1'b0, 8'h00, 1, 0);
      run_command(OP_RBYTE, 1'b1, 8'hFF, 0, 0);
      run_command(OP_RBIT, 1'b0, 8'h00, 1, 0);
      // command while busy is turned away
      send_item(OP_WBYTE, 1'b1, 8'h3C, 1'b1);
      send_item(OP_RESET, 1'b0, 8'h00, 1'b1);
      send_item(OP_RBIT, 1'b0, 8'h00, 1'b1);
      drain_bus(0, 0);
      // unused codes and a tick with nothing running
      send_item(3'd6, 1'b0, 8'h00, 1'b0);
      send_item(3'd7, 1'b1, 8'hFF, 1'b1);
      send_item(OP_TICK, 1'b1, 8'h81, 1'b0);
      settle();

      // short pulse not below the write slot: released part skipped
      apply_timing(10'd2, 10'd3, 10'd2, 10'd15, 10'd3, 10'd0, 10'd5, 10'd1);
      run_command(OP_WBIT, 1'b0, 8'h01, -1, 0);
      run_command(OP_WBYTE, 1'b1, 8'h55, -1, 0);
      run_command(OP_RBYTE, 1'b0, 8'h00, -1, 0);
      settle();

      // every register at its top, written with all ten bits set
      apply_timing(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
      run_command(OP_WBIT, 1'b1, 8'h00, -1, 0);
      run_command(OP_WBIT, 1'b0, 8'h0F, -1, 0);
      run_command(OP_RBIT, 1'b1, 8'h00, 0, 0);
      settle();

      // random timing setups with random traffic, the last one without idling
      for (int p = 0; p < 4; p++) begin
         apply_timing(10'($urandom_range(0, 24)), 10'($urandom_range(0, 24)),
                      10'($urandom_range(0, 24)), 10'($urandom_range(0, 15)),
                      10'($urandom_range(0, 12)), 10'($urandom_range(0, 12)),
                      10'($urandom_range(0, 24)), 10'($urandom_range(0, 6)));
         random_phase(180, p == 3);
         send_idle = 1'b0;
         recv_idle = 1'b0;
         settle();
      end

      $display("Sent %0d items under %0d timing setups; %0d results checked",
               sent_items, setups, checked);
      $display("%0d commands ran to completion, %0d were turned away",
               done_seen, reject_seen);
      if (fail_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Timed out with %0d results outstanding", pending);
      $display("Regression FAIL");
      $finish;
   end

endmodule
